>>> rtl/tfdc_pkg.sv
package tfdc_pkg;

  localparam int PosWidth   = 8;
  localparam int AreaWidth  = 23;
  localparam int PctWidth   = 8;
  localparam int SpeedWidth = 8;
  localparam int IndexWidth = 8;
  localparam int DataWidth  = 23;

  // Register indexes on the configuration port.
  localparam logic [IndexWidth-1:0] REG_TARGET_X      = 8'd0;
  localparam logic [IndexWidth-1:0] REG_MIN_AREA      = 8'd1;
  localparam logic [IndexWidth-1:0] REG_BAND_LOW_PCT  = 8'd2;
  localparam logic [IndexWidth-1:0] REG_BAND_HIGH_PCT = 8'd3;

  localparam logic [PosWidth-1:0]  TARGET_X_RESET      = 8'd80;
  localparam logic [AreaWidth-1:0] MIN_AREA_RESET      = 23'd10000;
  localparam logic [PctWidth-1:0]  BAND_LOW_PCT_RESET  = 8'd70;
  localparam logic [PctWidth-1:0]  BAND_HIGH_PCT_RESET = 8'd140;

  // Terms are scaled integers in units of 1e-5.
  localparam int IntegLimit  = 50;
  localparam int HErrGain    = 4000;
  localparam int HIntGain    = 9;
  localparam int VErrGain    = 500;
  localparam int TermLimit   = 300000;
  localparam int TermDead    = 100000;
  // The vertical term saturates and dead-bands directly on the area difference.
  localparam int DiffLimit   = TermLimit / VErrGain;
  localparam int DiffDead    = TermDead / VErrGain;
  localparam int AreaScale   = 100;

  // Speed = SpeedBase + floor((h + v + SpeedOffset) / 20000), offset sum in 0..1200000.
  localparam int SpeedBase   = 123;
  localparam int SpeedOffset = 600000;
  localparam int QuotShift   = 5;
  localparam int RecipShift  = 24;
  localparam int Recip       = ((1 << RecipShift) + 624) / 625;

  typedef struct packed {
    logic [PosWidth-1:0]  pos_x;
    logic [AreaWidth-1:0] object_area;
  } item_t;

  typedef struct packed {
    logic [SpeedWidth-1:0] left_speed;
    logic [SpeedWidth-1:0] right_speed;
  } speed_t;

endpackage

>>> rtl/target_follow_drive_controller.sv
// An accepted item word is registered in the term stage, then in the speed stage.
// Throughput: one item per cycle unless the output stalls; the term-forming stage updates
// the integral and target area per item above the floor, so items follow back to back.
// Reset (rst, synchronous, active high) restores register defaults, clears the integral
// and the latched target area, and empties both pipeline stages.
module target_follow_drive_controller
  import tfdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  speed_valid,
  input  logic                  speed_stall,
  output speed_t                speed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [DataWidth-1:0]  cfg_data
);

  logic [PosWidth-1:0]  target_x;
  logic [AreaWidth-1:0] min_area;
  logic [PctWidth-1:0]  band_low_pct;
  logic [PctWidth-1:0]  band_high_pct;

  logic signed [6:0]    integ;
  logic [AreaWidth-1:0] target_area;
  logic                 target_valid;

  // Term stage.
  logic                 term_valid;
  logic                 term_seen;
  logic signed [19:0]   term_h;
  logic signed [10:0]   term_dc;

  logic out_free;
  logic term_free;
  logic accept;

  assign cfg_ready  = 1'b1;
  assign out_free   = !speed_valid || !speed_stall;
  assign term_free  = !term_valid || out_free;
  assign item_stall = !term_free;
  assign accept     = item_valid && term_free;

  // Term computation from the incoming item and the current state.
  logic                 seen;
  logic [AreaWidth-1:0] tgt;
  logic signed [8:0]    err;
  logic signed [9:0]    acc;
  logic signed [6:0]    integ_next;
  logic signed [21:0]   h_raw;
  logic signed [19:0]   h_term;
  logic signed [23:0]   diff;
  logic signed [10:0]   dc;
  logic [30:0]          area_scaled;
  logic [30:0]          low_prod;
  logic [30:0]          high_prod;
  logic                 in_band;

  always_comb begin
    seen = item.object_area > min_area;
    tgt  = target_valid ? target_area : item.object_area;
    err  = $signed({1'b0, item.pos_x}) - $signed({1'b0, target_x});
    acc  = 10'(integ) + 10'(err);
    if (acc > 10'(IntegLimit)) begin
      integ_next = 7'(IntegLimit);
    end else if (acc < -10'(IntegLimit)) begin
      integ_next = -7'(IntegLimit);
    end else begin
      integ_next = acc[6:0];
    end

    h_raw = 22'(HErrGain * int'(err) + HIntGain * int'(integ_next));
    if (h_raw > 22'(TermLimit)) begin
      h_term = 20'(TermLimit);
    end else if (h_raw < -22'(TermLimit)) begin
      h_term = -20'(TermLimit);
    end else if (h_raw <= 22'(TermDead) && h_raw >= -22'(TermDead)) begin
      h_term = '0;
    end else begin
      h_term = h_raw[19:0];
    end

    diff = $signed({1'b0, tgt}) - $signed({1'b0, item.object_area});
    if (diff > 24'(DiffLimit)) begin
      dc = 11'(DiffLimit);
    end else if (diff < -24'(DiffLimit)) begin
      dc = -11'(DiffLimit);
    end else if (diff <= 24'(DiffDead) && diff >= -24'(DiffDead)) begin
      dc = '0;
    end else begin
      dc = diff[10:0];
    end

    area_scaled = 31'(item.object_area) * 31'(AreaScale);
    low_prod    = 31'(tgt) * 31'(band_low_pct);
    high_prod   = 31'(tgt) * 31'(band_high_pct);
    in_band     = (area_scaled > low_prod) && (area_scaled < high_prod);
    if (in_band) begin
      dc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x      <= TARGET_X_RESET;
      min_area      <= MIN_AREA_RESET;
      band_low_pct  <= BAND_LOW_PCT_RESET;
      band_high_pct <= BAND_HIGH_PCT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TARGET_X:      target_x      <= cfg_data[PosWidth-1:0];
        REG_MIN_AREA:      min_area      <= cfg_data[AreaWidth-1:0];
        REG_BAND_LOW_PCT:  band_low_pct  <= cfg_data[PctWidth-1:0];
        REG_BAND_HIGH_PCT: band_high_pct <= cfg_data[PctWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ        <= '0;
      target_area  <= '0;
      target_valid <= 1'b0;
      term_valid   <= 1'b0;
    end else begin
      if (accept && seen) begin
        integ <= integ_next;
        if (!target_valid) begin
          target_area  <= item.object_area;
          target_valid <= 1'b1;
        end
      end
      if (term_free) begin
        term_valid <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      term_seen <= seen;
      term_h    <= h_term;
      term_dc   <= dc;
    end
  end

  // Speed stage: divide by 20000 as a shift by 5 and a reciprocal multiply for 625.
  logic signed [19:0] v_term;
  logic signed [21:0] left_num;
  logic signed [21:0] right_num;
  logic [15:0]        left_x;
  logic [15:0]        right_x;
  logic [30:0]        left_prod;
  logic [30:0]        right_prod;
  speed_t             speed_next;

  always_comb begin
    v_term     = 20'(int'(term_dc) * VErrGain);
    left_num   = 22'(SpeedOffset) + 22'(term_h) + 22'(v_term);
    right_num  = 22'(SpeedOffset) + 22'(term_h) - 22'(v_term);
    left_x     = left_num[QuotShift +: 16];
    right_x    = right_num[QuotShift +: 16];
    left_prod  = 31'(left_x) * 31'(Recip);
    right_prod = 31'(right_x) * 31'(Recip);
    if (term_seen) begin
      speed_next.left_speed  = 8'(SpeedBase) + {1'b0, left_prod[RecipShift +: 7]};
      speed_next.right_speed = 8'(SpeedBase) + {1'b0, right_prod[RecipShift +: 7]};
    end else begin
      speed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_valid <= 1'b0;
    end else if (out_free) begin
      speed_valid <= term_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && term_valid) begin
      speed <= speed_next;
    end
  end

endmodule

>>> rtl/tfdc_checker.sv
module tfdc_checker
  import tfdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_stall,
  input item_t                 item,
  input logic                  speed_valid,
  input logic                  speed_stall,
  input speed_t                speed,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [IndexWidth-1:0] cfg_index,
  input logic [DataWidth-1:0]  cfg_data
);

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !speed_valid)
    else $error("speed word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    speed_valid && speed_stall |=> speed_valid && $stable(speed))
    else $error("stalled speed word changed");

  // Either both servos stop or both lie in the drive range.
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    speed_valid |-> (speed.left_speed == 8'd0 && speed.right_speed == 8'd0) ||
      (speed.left_speed >= 8'd123 && speed.left_speed <= 8'd183 &&
       speed.right_speed >= 8'd123 && speed.right_speed <= 8'd183))
    else $error("speed word out of range");

  // With no word waiting at the output, the block always takes an item.
  a_no_idle_stall: assert property (@(posedge clk) !speed_valid |-> !item_stall)
    else $error("item stalled while output is empty");

endmodule

bind target_follow_drive_controller tfdc_checker u_tfdc_checker (.*);

>>> tb/drive_speed_checker.sv
`timescale 1ns / 100ps

module drive_speed_checker
  import tfdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_stall,
  input  item_t                 item,
  input  logic                  speed_valid,
  input  logic                  speed_stall,
  input  speed_t                speed,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [DataWidth-1:0]  cfg_data,
  output int                    mismatches,
  output int                    speeds_owed
);

  // Terms are kept as scaled integers in units of 1e-5.
  localparam longint IntegCap   = 50;
  localparam longint PosGain    = 4000;
  localparam longint IntGain    = 9;
  localparam longint AreaGain   = 500;
  localparam longint TermCap    = 300000;
  localparam longint DeadZone   = 100000;
  localparam longint NeutralCmd = 153;
  localparam longint CmdScale   = 20000;

  logic [PosWidth-1:0]  target_x_q;
  logic [AreaWidth-1:0] min_area_q;
  logic [PctWidth-1:0]  band_lo_q;
  logic [PctWidth-1:0]  band_hi_q;

  logic signed [6:0]    integ_q;
  logic [AreaWidth-1:0] target_area_q;
  logic                 target_latched;

  speed_t expected_speeds[$];
  speed_t want;

  function automatic longint shape_term(input longint t);
    longint r;
    r = t;
    if (r > TermCap) r = TermCap;
    else if (r < -TermCap) r = -TermCap;
    if (r <= DeadZone && r >= -DeadZone) r = 0;
    return r;
  endfunction

  // Works out the speed word for one item and, for an item above the area floor, advances the controller state.
  function automatic speed_t predict_speeds(input item_t word);
    longint px, tx, area, floor_area, tgt, lo, hi, err, acc, h, v, lnum, rnum;
    speed_t sp;
    px = longint'(word.pos_x);
    tx = longint'(target_x_q);
    area = longint'(word.object_area);
    floor_area = longint'(min_area_q);
    lo = longint'(band_lo_q);
    hi = longint'(band_hi_q);
    sp = '0;
    if (area <= floor_area) return sp;

    if (!target_latched) begin
      target_area_q = word.object_area;
      target_latched = 1'b1;
    end
    tgt = longint'(target_area_q);

    err = px - tx;
    acc = longint'(integ_q);
    acc = acc + err;
    if (acc > IntegCap) acc = IntegCap;
    else if (acc < -IntegCap) acc = -IntegCap;
    integ_q = 7'(acc);
    h = shape_term(PosGain * err + IntGain * acc);

    v = shape_term(AreaGain * (tgt - area));
    // The range-keeping term rests while the area sits strictly inside the band.
    if (100 * area > tgt * lo && 100 * area < tgt * hi) v = 0;

    lnum = NeutralCmd * CmdScale + h + v;
    rnum = NeutralCmd * CmdScale + h - v;
    sp.left_speed = 8'(lnum / CmdScale);
    sp.right_speed = 8'(rnum / CmdScale);
    return sp;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      target_x_q = TARGET_X_RESET;
      min_area_q = MIN_AREA_RESET;
      band_lo_q = BAND_LOW_PCT_RESET;
      band_hi_q = BAND_HIGH_PCT_RESET;
      integ_q = '0;
      target_area_q = '0;
      target_latched = 1'b0;
      mismatches = 0;
      expected_speeds.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_X:      target_x_q = cfg_data[PosWidth-1:0];
          REG_MIN_AREA:      min_area_q = cfg_data[AreaWidth-1:0];
          REG_BAND_LOW_PCT:  band_lo_q = cfg_data[PctWidth-1:0];
          REG_BAND_HIGH_PCT: band_hi_q = cfg_data[PctWidth-1:0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) expected_speeds.push_back(predict_speeds(item));
      if (speed_valid && !speed_stall) begin
        if (expected_speeds.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected speed word left %0d right %0d",
                   $time, speed.left_speed, speed.right_speed);
        end else begin
          want = expected_speeds.pop_front();
          if (speed.left_speed !== want.left_speed) begin
            mismatches++;
            $display("%0t: left_speed mismatch: expected %0d, actual %0d",
                     $time, want.left_speed, speed.left_speed);
          end
          if (speed.right_speed !== want.right_speed) begin
            mismatches++;
            $display("%0t: right_speed mismatch: expected %0d, actual %0d",
                     $time, want.right_speed, speed.right_speed);
          end
        end
      end
    end
    speeds_owed = expected_speeds.size();
  end

endmodule

>>> tb/target_follow_drive_controller_tb.sv
`timescale 1ns / 100ps

module target_follow_drive_controller_tb;
  import tfdc_pkg::*;

  localparam int MaxGap      = 17;
  localparam int LongHold    = 300;
  localparam int QuietLimit  = 5000;
  localparam int Phases      = 10;
  localparam int PhaseItems  = 93;
  localparam int BurstItems  = 40;
  localparam logic [AreaWidth-1:0] LatchedArea = 23'd20000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_stall;
  item_t                 item = '0;
  logic                  speed_valid;
  logic                  speed_stall = 1'b0;
  speed_t                speed;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IndexWidth-1:0] cfg_index = '0;
  logic [DataWidth-1:0]  cfg_data = '0;

  int mismatches;
  int speeds_owed;
  int quiet_cycles = 0;
  bit tx_idle = 1'b1;
  bit burst_phase = 1'b0;

  // Register values that the random items are aimed around.
  logic [PosWidth-1:0]  aim_x = TARGET_X_RESET;
  logic [AreaWidth-1:0] aim_floor = MIN_AREA_RESET;

  always #5 clk = ~clk;

  target_follow_drive_controller DUT (.*);

  drive_speed_checker speed_check (.*);

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (speed_valid && !speed_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_item(input logic [PosWidth-1:0] px, input logic [AreaWidth-1:0] area);
    int gap;
    gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{pos_x: px, object_area: area};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Stops offering items and waits until every speed word owed has come out.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (speeds_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [DataWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Upper data bits of the narrow registers carry junk, and one write goes
  // to an index that holds no register.
  task automatic set_regs(input logic [PosWidth-1:0] tx, input logic [AreaWidth-1:0] floor_area,
                          input logic [PctWidth-1:0] lo, input logic [PctWidth-1:0] hi);
    logic [14:0] junk;
    junk = 15'($urandom());
    write_reg(REG_TARGET_X, {junk, tx});
    write_reg(REG_MIN_AREA, floor_area);
    write_reg(REG_BAND_LOW_PCT, {~junk, lo});
    write_reg(REG_BAND_HIGH_PCT, {junk, hi});
    write_reg(IndexWidth'($urandom_range(4, 255)), DataWidth'($urandom()));
    cfg_valid <= 1'b0;
    aim_x = tx;
    aim_floor = floor_area;
  endtask

  task automatic set_random_regs();
    logic [PosWidth-1:0]  tx;
    logic [AreaWidth-1:0] floor_area;
    logic [PctWidth-1:0]  lo;
    logic [PctWidth-1:0]  hi;
    case ($urandom_range(0, 3))
      0: tx = 8'd0;
      1: tx = 8'd159;
      default: tx = PosWidth'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0: floor_area = '0;
      1: floor_area = 23'd4896000;
      2: floor_area = '1;
      default: floor_area = AreaWidth'($urandom_range(0, 19000));
    endcase
    case ($urandom_range(0, 3))
      0: begin
        lo = BAND_LOW_PCT_RESET;
        hi = BAND_HIGH_PCT_RESET;
      end
      1: begin
        lo = PctWidth'($urandom_range(90, 99));
        hi = PctWidth'($urandom_range(101, 110));
      end
      default: begin
        lo = PctWidth'($urandom());
        hi = PctWidth'($urandom());
      end
    endcase
    set_regs(tx, floor_area, lo, hi);
  endtask

  // Half of the areas sit near the latched target, where the dead zone, the clamps
  // and the band edges all lie; a share sits at the floor; the rest sweep the field.
  task automatic send_random_item();
    logic [PosWidth-1:0]  px;
    logic [AreaWidth-1:0] area;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) area = AreaWidth'(LatchedArea + $urandom_range(0, 1400) - 700);
    else if (pick < 50) area = AreaWidth'(LatchedArea + $urandom_range(0, 24000) - 12000);
    else if (pick < 62) area = AreaWidth'(aim_floor + $urandom_range(0, 2) - 1);
    else if (pick < 80) area = AreaWidth'($urandom_range(0, 60000));
    else area = AreaWidth'($urandom());
    if ($urandom_range(0, 1)) px = PosWidth'(aim_x + $urandom_range(0, 60) - 30);
    else px = PosWidth'($urandom());
    send_item(px, area);
  endtask

  initial begin : receiver
    int gap;
    int served;
    bit rx_idle;
    bit held;
    served = 0;
    rx_idle = 1'b1;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (burst_phase && !held) begin
        held = 1'b1;
        speed_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
      end
      if (served % 50 == 0) rx_idle = $urandom_range(0, 2) != 0;
      gap = rx_idle ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        speed_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      speed_stall <= 1'b0;
      @(posedge clk);
      while (!(speed_valid && !speed_stall)) @(posedge clk);
      served++;
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: no object below and at the floor, then the first object
    // latches a target of 20000 so that 70 and 140 percent fall on whole areas.
    send_item(8'd0, 23'd0);
    send_item(8'd159, 23'd10000);
    send_item(8'd80, LatchedArea);
    send_item(8'd159, LatchedArea);
    send_item(8'd0, LatchedArea);
    send_item(8'd255, 23'd14000);
    send_item(8'd80, 23'd14001);
    send_item(8'd80, 23'd27999);
    send_item(8'd80, 23'd28000);
    send_item(8'd0, '1);
    drain_results();

    // Empty band and no floor: the range term alone around its dead zone
    // and its clamp.
    set_regs(8'd159, '0, 8'd0, 8'd0);
    send_item(8'd159, 23'd1);
    send_item(8'd159, 23'd19800);
    send_item(8'd159, 23'd19799);
    send_item(8'd159, 23'd20200);
    send_item(8'd159, 23'd20201);
    send_item(8'd159, 23'd19400);
    drain_results();

    // Inverted band with a floor of 4896000.
    set_regs(8'd0, 23'd4896000, 8'd255, 8'd0);
    send_item(8'd255, 23'd4896000);
    send_item(8'd0, 23'd4896001);
    send_item(8'd255, '1);
    drain_results();
    set_regs(TARGET_X_RESET, MIN_AREA_RESET, BAND_LOW_PCT_RESET, BAND_HIGH_PCT_RESET);

    for (int phase = 0; phase < Phases; phase++) begin
      tx_idle = $urandom_range(0, 3) != 0;
      if (phase == Phases / 2) begin
        // Back-to-back items while the receiver holds off for a long time.
        tx_idle = 1'b0;
        burst_phase = 1'b1;
        for (int n = 0; n < BurstItems; n++) send_random_item();
        burst_phase = 1'b0;
        tx_idle = 1'b1;
      end
      for (int n = 0; n < PhaseItems; n++) send_random_item();
      drain_results();
      if (phase < Phases - 1) set_random_regs();
    end

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

>>> target_follow_drive_controller.f
rtl/tfdc_pkg.sv
rtl/target_follow_drive_controller.sv
rtl/tfdc_checker.sv
tb/drive_speed_checker.sv
tb/target_follow_drive_controller_tb.sv
